[rtl/lrupr_pkg.sv]
// Shared types and constants for the LRU page replacement block.
// Used by lrupr_cell and lru_page_replacement; depends on nothing else.
package lrupr_pkg;

    localparam int CFG_W   = 5;
    localparam int FAULT_W = 32;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    // Action broadcast from the control to every cell once a scan finishes.
    typedef enum logic [1:0] {
        UPD_NONE,
        UPD_HIT,
        UPD_FILL,
        UPD_EVICT
    } t_upd_kind;

    // Flags that travel with a probe from cell to cell.
    typedef struct packed {
        logic valid;
        logic hit;
        logic free_found;
        logic lru_found;
    } t_probe_flags;

endpackage

[rtl/lru_page_replacement.sv]
// LRU page replacement: a row of FRAMES cells scanned by a moving probe,
// plus the decision and counter logic. Depends on lrupr_pkg and lrupr_cell.
//
//  channel   handshake                 payload
//  -------   -----------------------   ------------------------------------------
//  request   start, busy               i_page_number
//  result    o_result_valid (strobe)   o_hit, o_evicted, o_evicted_page,
//                                      o_frame_slot, o_fault_total
//  config    i_cfg_valid, o_cfg_ready  i_cfg_data (frames_in_use)
//
// The probe crosses the row one cell per clock. In the cycle it leaves the last
// cell, the control decides, updates every cell and registers the result.
// The result strobe is high in the cycle busy drops, so the next request can be
// taken while that result is on the ports. The receiver cannot stall.
// Configuration writes are held off while a request is in the row.
// Reset clears all frames, the fault count and sets frames_in_use to 16.
module lru_page_replacement import lrupr_pkg::*; #(
    parameter int FRAMES    = 16,
    parameter int PAGE_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [PAGE_BITS-1:0]        i_page_number,
    output logic                        o_result_valid,
    output logic                        o_hit,
    output logic                        o_evicted,
    output logic [PAGE_BITS-1:0]        o_evicted_page,
    output logic [$clog2(FRAMES)-1:0]   o_frame_slot,
    output logic [FAULT_W-1:0]          o_fault_total,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [CFG_W-1:0]            i_cfg_data
);

    localparam int RANK_W = $clog2(FRAMES);
    localparam int CNT_W  = $clog2(FRAMES + 1);
    localparam int LIM_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    // Probe taps: index 0 is the injected request, index FRAMES is the last cell.
    t_probe_flags         w_flags     [FRAMES+1];
    logic [PAGE_BITS-1:0] w_page      [FRAMES+1];
    logic [RANK_W-1:0]    w_hit_slot  [FRAMES+1];
    logic [RANK_W-1:0]    w_hit_rank  [FRAMES+1];
    logic [RANK_W-1:0]    w_free_slot [FRAMES+1];
    logic [RANK_W-1:0]    w_lru_slot  [FRAMES+1];
    logic [PAGE_BITS-1:0] w_lru_page  [FRAMES+1];

    logic                 r_busy;
    logic [CFG_W-1:0]     r_frames_in_use;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [FAULT_W-1:0]   r_fault, n_fault;

    logic                 r_res_valid;
    logic                 r_hit, n_hit;
    logic                 r_evicted, n_evicted;
    logic [PAGE_BITS-1:0] r_ev_page, n_ev_page;
    logic [RANK_W-1:0]    r_slot, n_slot;

    t_upd_kind            upd_kind;
    logic [RANK_W-1:0]    upd_bound;
    logic [RANK_W-1:0]    lru_rank;
    logic [LIM_W-1:0]     cfg_ext;
    logic [LIM_W-1:0]     lim;
    logic                 accept;
    logic                 done;
    t_probe_flags         last;

    assign accept = start && !r_busy;
    assign last   = w_flags[FRAMES];
    assign done   = last.valid;

    always_comb begin
        w_flags[0]            = '0;
        w_flags[0].valid      = accept;
        w_page[0]             = i_page_number;
        w_hit_slot[0]         = '0;
        w_hit_rank[0]         = '0;
        w_free_slot[0]        = '0;
        w_lru_slot[0]         = '0;
        w_lru_page[0]         = '0;
    end

    // The resident ranks are always 0 .. count-1, so the oldest frame has count-1.
    assign lru_rank = RANK_W'(r_count - CNT_W'(1));

    for (genvar g = 0; g < FRAMES; g++) begin : g_cell
        lrupr_cell #(
            .FRAMES    (FRAMES),
            .PAGE_BITS (PAGE_BITS),
            .CELL_IDX  (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_flags     (w_flags[g]),
            .i_page      (w_page[g]),
            .i_hit_slot  (w_hit_slot[g]),
            .i_hit_rank  (w_hit_rank[g]),
            .i_free_slot (w_free_slot[g]),
            .i_lru_slot  (w_lru_slot[g]),
            .i_lru_page  (w_lru_page[g]),
            .i_lru_rank  (lru_rank),
            .o_flags     (w_flags[g+1]),
            .o_page      (w_page[g+1]),
            .o_hit_slot  (w_hit_slot[g+1]),
            .o_hit_rank  (w_hit_rank[g+1]),
            .o_free_slot (w_free_slot[g+1]),
            .o_lru_slot  (w_lru_slot[g+1]),
            .o_lru_page  (w_lru_page[g+1]),
            .i_upd_kind  (upd_kind),
            .i_upd_slot  (n_slot),
            .i_upd_bound (upd_bound),
            .i_upd_page  (w_page[FRAMES])
        );
    end

    // A limit of zero acts as one, and a limit above the row acts as the row.
    always_comb begin
        cfg_ext = LIM_W'(r_frames_in_use);
        if (cfg_ext == '0) begin
            lim = LIM_W'(1);
        end else if (cfg_ext > LIM_W'(FRAMES)) begin
            lim = LIM_W'(FRAMES);
        end else begin
            lim = cfg_ext;
        end
    end

    always_comb begin
        upd_kind  = UPD_NONE;
        upd_bound = '0;
        n_count   = r_count;
        n_fault   = r_fault;
        n_hit     = 1'b0;
        n_evicted = 1'b0;
        n_ev_page = '0;
        n_slot    = '0;
        if (done) begin
            if (last.hit) begin
                upd_kind  = UPD_HIT;
                upd_bound = w_hit_rank[FRAMES];
                n_hit     = 1'b1;
                n_slot    = w_hit_slot[FRAMES];
            end else begin
                if (r_fault != '1) begin
                    n_fault = r_fault + FAULT_W'(1);
                end
                if (LIM_W'(r_count) < lim) begin
                    upd_kind = UPD_FILL;
                    n_slot   = w_free_slot[FRAMES];
                    n_count  = r_count + CNT_W'(1);
                end else begin
                    upd_kind  = UPD_EVICT;
                    upd_bound = lru_rank;
                    n_slot    = w_lru_slot[FRAMES];
                    n_evicted = 1'b1;
                    n_ev_page = w_lru_page[FRAMES];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy          <= 1'b0;
            r_frames_in_use <= CFG_RESET;
            r_count         <= '0;
            r_fault         <= '0;
            r_res_valid     <= 1'b0;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
            end else if (done) begin
                r_busy <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_frames_in_use <= i_cfg_data;
            end
            r_count     <= n_count;
            r_fault     <= n_fault;
            r_res_valid <= done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_hit     <= n_hit;
            r_evicted <= n_evicted;
            r_ev_page <= n_ev_page;
            r_slot    <= n_slot;
        end
    end

    assign busy           = r_busy;
    assign o_cfg_ready    = !r_busy;
    assign o_result_valid = r_res_valid;
    assign o_hit          = r_hit;
    assign o_evicted      = r_evicted;
    assign o_evicted_page = r_ev_page;
    assign o_frame_slot   = r_slot;
    assign o_fault_total  = r_fault;

`ifndef SYNTHESIS
    // A fill needs a free frame somewhere in the row.
    a_fill_has_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (done && !last.hit && LIM_W'(r_count) < lim) |-> last.free_found)
        else $error("fill decided but no free frame was found");

    // An eviction needs a frame holding the oldest rank.
    a_evict_has_lru: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (done && !last.hit && !(LIM_W'(r_count) < lim)) |-> last.lru_found)
        else $error("eviction decided but no least recent frame was found");

    // Only one request is in the row at a time.
    a_single_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |-> r_busy && !accept)
        else $error("scan finished outside a busy request");

    a_result_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |=> o_result_valid && !busy)
        else $error("result strobe missing after scan");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        LIM_W'(r_count) <= LIM_W'(FRAMES))
        else $error("resident count exceeds frame count");
`endif

endmodule

[rtl/lrupr_cell.sv]
// One frame of the replacement row: resident page, valid bit and recency rank,
// plus one stage of the probe that walks the row. Depends on lrupr_pkg.
module lrupr_cell import lrupr_pkg::*; #(
    parameter int FRAMES    = 16,
    parameter int PAGE_BITS = 16,
    parameter int CELL_IDX  = 0
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Probe coming from the left neighbor.
    input  t_probe_flags                i_flags,
    input  logic [PAGE_BITS-1:0]        i_page,
    input  logic [$clog2(FRAMES)-1:0]   i_hit_slot,
    input  logic [$clog2(FRAMES)-1:0]   i_hit_rank,
    input  logic [$clog2(FRAMES)-1:0]   i_free_slot,
    input  logic [$clog2(FRAMES)-1:0]   i_lru_slot,
    input  logic [PAGE_BITS-1:0]        i_lru_page,
    // Rank that marks the least recently used frame.
    input  logic [$clog2(FRAMES)-1:0]   i_lru_rank,
    // Probe handed to the right neighbor.
    output t_probe_flags                o_flags,
    output logic [PAGE_BITS-1:0]        o_page,
    output logic [$clog2(FRAMES)-1:0]   o_hit_slot,
    output logic [$clog2(FRAMES)-1:0]   o_hit_rank,
    output logic [$clog2(FRAMES)-1:0]   o_free_slot,
    output logic [$clog2(FRAMES)-1:0]   o_lru_slot,
    output logic [PAGE_BITS-1:0]        o_lru_page,
    // State update broadcast to all cells.
    input  t_upd_kind                   i_upd_kind,
    input  logic [$clog2(FRAMES)-1:0]   i_upd_slot,
    input  logic [$clog2(FRAMES)-1:0]   i_upd_bound,
    input  logic [PAGE_BITS-1:0]        i_upd_page
);

    localparam int RANK_W = $clog2(FRAMES);
    localparam logic [RANK_W-1:0] MY_IDX = RANK_W'(CELL_IDX);

    logic [PAGE_BITS-1:0] r_page;
    logic                 r_valid;
    logic [RANK_W-1:0]    r_rank;

    t_probe_flags         r_flags, n_flags;
    logic [PAGE_BITS-1:0] r_pg;
    logic [RANK_W-1:0]    r_hit_slot, n_hit_slot;
    logic [RANK_W-1:0]    r_hit_rank, n_hit_rank;
    logic [RANK_W-1:0]    r_free_slot, n_free_slot;
    logic [RANK_W-1:0]    r_lru_slot, n_lru_slot;
    logic [PAGE_BITS-1:0] r_lru_page, n_lru_page;

    logic match;

    assign match = r_valid && (r_page == i_page);

    always_comb begin
        n_flags     = i_flags;
        n_hit_slot  = i_hit_slot;
        n_hit_rank  = i_hit_rank;
        n_free_slot = i_free_slot;
        n_lru_slot  = i_lru_slot;
        n_lru_page  = i_lru_page;
        if (match && !i_flags.hit) begin
            n_flags.hit = 1'b1;
            n_hit_slot  = MY_IDX;
            n_hit_rank  = r_rank;
        end
        if (!r_valid && !i_flags.free_found) begin
            n_flags.free_found = 1'b1;
            n_free_slot        = MY_IDX;
        end
        if (r_valid && (r_rank == i_lru_rank) && !i_flags.lru_found) begin
            n_flags.lru_found = 1'b1;
            n_lru_slot        = MY_IDX;
            n_lru_page        = r_page;
        end
    end

    // Probe stage: shifts one cell to the right on every clock.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else begin
            r_flags <= n_flags;
        end
        r_pg        <= i_page;
        r_hit_slot  <= n_hit_slot;
        r_hit_rank  <= n_hit_rank;
        r_free_slot <= n_free_slot;
        r_lru_slot  <= n_lru_slot;
        r_lru_page  <= n_lru_page;
    end

    // Frame state. The chosen frame becomes most recent; other valid frames
    // that were more recent than the bound age by one, and a fill ages all.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rank  <= '0;
        end else if (i_upd_kind != UPD_NONE) begin
            if (i_upd_slot == MY_IDX) begin
                r_valid <= 1'b1;
                r_rank  <= '0;
            end else if (r_valid && (i_upd_kind == UPD_FILL || r_rank < i_upd_bound)) begin
                r_rank <= r_rank + RANK_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((i_upd_kind == UPD_FILL || i_upd_kind == UPD_EVICT) && i_upd_slot == MY_IDX) begin
            r_page <= i_upd_page;
        end
    end

    assign o_flags     = r_flags;
    assign o_page      = r_pg;
    assign o_hit_slot  = r_hit_slot;
    assign o_hit_rank  = r_hit_rank;
    assign o_free_slot = r_free_slot;
    assign o_lru_slot  = r_lru_slot;
    assign o_lru_page  = r_lru_page;

endmodule

[test/tb_lru_page_replacement.sv]
// Self-checking testbench for lru_page_replacement: a queue-fed request driver,
// a result monitor with an LRU predictor, and a stall watchdog.
// Depends on lrupr_pkg and the lru_page_replacement RTL.
`timescale 1ns / 100ps

module tb_lru_page_replacement;
    import lrupr_pkg::*;

    localparam int FRAMES      = 16;
    localparam int PAGE_BITS   = 16;
    localparam int SLOT_W      = $clog2(FRAMES);
    localparam int MAX_GAP     = 24;
    localparam int STALL_LIMIT = 1000;

    typedef struct packed {
        logic                 hit;
        logic                 evicted;
        logic [PAGE_BITS-1:0] evicted_page;
        logic [SLOT_W-1:0]    frame_slot;
        logic [FAULT_W-1:0]   fault_total;
    } t_page_outcome;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    logic [PAGE_BITS-1:0]   i_page_number;
    logic                   o_result_valid;
    logic                   o_hit;
    logic                   o_evicted;
    logic [PAGE_BITS-1:0]   o_evicted_page;
    logic [SLOT_W-1:0]      o_frame_slot;
    logic [FAULT_W-1:0]     o_fault_total;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_W-1:0]       i_cfg_data;

    lru_page_replacement #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_page_number  (i_page_number),
        .o_result_valid (o_result_valid),
        .o_hit          (o_hit),
        .o_evicted      (o_evicted),
        .o_evicted_page (o_evicted_page),
        .o_frame_slot   (o_frame_slot),
        .o_fault_total  (o_fault_total),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    logic [PAGE_BITS-1:0] page_queue[$];
    t_page_outcome        outcome_queue[$];
    int                   error_count;
    int                   sender_idle_pct;
    int                   gap_left;
    int                   quiet_cycles;

    // Predictor state.
    logic [PAGE_BITS-1:0] frame_page[FRAMES];
    logic                 frame_valid[FRAMES];
    logic [SLOT_W-1:0]    frame_rank[FRAMES];
    logic [CFG_W:0]       resident_count;
    logic [FAULT_W-1:0]   fault_count;
    logic [CFG_W-1:0]     frames_cfg;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic void clear_frames();
        for (int i = 0; i < FRAMES; i++) begin
            frame_page[i]  = '0;
            frame_valid[i] = 1'b0;
            frame_rank[i]  = '0;
        end
        resident_count = '0;
        fault_count    = '0;
        frames_cfg     = CFG_RESET;
    endfunction

    // Frame f becomes most recent; valid frames more recent than bound age by one.
    function automatic void touch_frame(int f, int unsigned bound);
        for (int i = 0; i < FRAMES; i++) begin
            if (i != f && frame_valid[i] && frame_rank[i] < bound)
                frame_rank[i] = frame_rank[i] + 1'b1;
        end
        frame_rank[f] = '0;
    endfunction

    function automatic t_page_outcome lookup_page(logic [PAGE_BITS-1:0] page);
        t_page_outcome r;
        int            slot;
        int unsigned   lim;
        int unsigned   best;
        r    = '0;
        slot = -1;
        for (int i = 0; i < FRAMES; i++) begin
            if (slot < 0 && frame_valid[i] && frame_page[i] == page)
                slot = i;
        end
        if (slot >= 0) begin
            r.hit = 1'b1;
            touch_frame(slot, frame_rank[slot]);
        end else begin
            if (fault_count != '1)
                fault_count = fault_count + 1'b1;
            lim = frames_cfg;
            if (lim < 1)
                lim = 1;
            if (lim > FRAMES)
                lim = FRAMES;
            if (resident_count < lim) begin
                for (int i = 0; i < FRAMES; i++) begin
                    if (slot < 0 && !frame_valid[i])
                        slot = i;
                end
            end
            if (slot >= 0) begin
                frame_valid[slot] = 1'b1;
                frame_page[slot]  = page;
                resident_count    = resident_count + 1'b1;
                touch_frame(slot, 32'hFFFF_FFFF);
            end else begin
                // The oldest rank wins; ties go to the lowest frame.
                best = 0;
                for (int i = 0; i < FRAMES; i++) begin
                    if (frame_valid[i] && (slot < 0 || frame_rank[i] > best)) begin
                        slot = i;
                        best = frame_rank[i];
                    end
                end
                if (slot < 0)
                    slot = 0;
                r.evicted         = 1'b1;
                r.evicted_page    = frame_page[slot];
                frame_page[slot]  = page;
                frame_valid[slot] = 1'b1;
                touch_frame(slot, frame_rank[slot]);
            end
        end
        r.frame_slot  = SLOT_W'(slot);
        r.fault_total = fault_count;
        return r;
    endfunction

    task automatic check_field(string field, logic [FAULT_W-1:0] want,
                               logic [FAULT_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, want, got);
            error_count++;
        end
    endtask

    // Request driver. A pending request is held until busy is low.
    always @(posedge i_clk) begin : request_driver
        if (!i_rst_n) begin
            start    <= 1'b0;
            gap_left = 0;
        end else if (!start || !busy) begin
            if (start && gap_left == 0 && $urandom_range(99) < sender_idle_pct)
                gap_left = $urandom_range(1, MAX_GAP);
            if (gap_left > 0) begin
                start <= 1'b0;
                gap_left--;
            end else if (page_queue.size() > 0) begin
                start         <= 1'b1;
                i_page_number <= page_queue.pop_front();
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Result monitor and predictor.
    always @(posedge i_clk) begin : result_monitor
        t_page_outcome want;
        if (!i_rst_n) begin
            clear_frames();
        end else begin
            if (o_result_valid) begin
                if (outcome_queue.size() == 0) begin
                    $display("%0t: result with no request pending, expected none, actual %0h",
                             $time, {o_hit, o_evicted, o_evicted_page, o_frame_slot,
                                     o_fault_total});
                    error_count++;
                end else begin
                    want = outcome_queue.pop_front();
                    check_field("hit", want.hit, o_hit);
                    check_field("evicted", want.evicted, o_evicted);
                    check_field("evicted_page", want.evicted_page, o_evicted_page);
                    check_field("frame_slot", want.frame_slot, o_frame_slot);
                    check_field("fault_total", want.fault_total, o_fault_total);
                end
            end
            if (i_cfg_valid && o_cfg_ready)
                frames_cfg = i_cfg_data;
            if (start && !busy) begin
                want          = lookup_page(i_page_number);
                outcome_queue = {outcome_queue, want};
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (start && !busy) || o_result_valid || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("lru_page_replacement verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Sampled after the falling edge so that every update of the edge is visible.
    task automatic wait_drained();
        @(negedge i_clk);
        while (page_queue.size() != 0 || start || outcome_queue.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_frames(logic [CFG_W-1:0] value);
        wait_drained();
        repeat (FRAMES + 4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_random_phase(logic [CFG_W-1:0] cfg, int idle_pct, int count);
        logic [PAGE_BITS-1:0] pool[$];
        logic [PAGE_BITS-1:0] page;
        int                   lim;
        int                   pick;
        write_frames(cfg);
        sender_idle_pct = idle_pct;
        lim = (cfg < 1) ? 1 : (cfg > FRAMES) ? FRAMES : cfg;
        // A working set a little larger than the limit mixes hits and evictions.
        repeat (lim + $urandom_range(1, 6))
            pool = {pool, PAGE_BITS'($urandom)};
        page = pool[0];
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(99);
            if (pick >= 85)
                page = PAGE_BITS'($urandom);
            else if (pick >= 10)
                page = pool[$urandom_range(pool.size() - 1)];
            page_queue = {page_queue, page};
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_page_number   = '0;
        i_cfg_valid     = 1'b0;
        i_cfg_data      = '0;
        error_count     = 0;
        sender_idle_pct = 0;
        quiet_cycles    = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Fills, hits and the extreme page numbers under the reset limit.
        page_queue = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555};
        // A limit of zero acts as one, below the resident count: misses evict.
        write_frames(5'd0);
        page_queue = '{16'h1234, 16'h5555, 16'h4321, 16'h4321};
        write_frames(5'd2);
        page_queue = '{16'h0001, 16'h8000};
        // Raising the limit again reopens the lowest free frames.
        write_frames(5'd6);
        page_queue = '{16'h0002, 16'h0003, 16'h0004, 16'h0002, 16'h0003};
        // Values above the frame count act as the full frame count.
        write_frames(5'd31);
        page_queue = '{16'h7FFF, 16'hFFFE, 16'h0000, 16'h1234};

        run_random_phase(5'd7, 0, 120);
        run_random_phase(CFG_W'($urandom_range(8, 15)), 75, 120);
        run_random_phase(5'd17, 15, 120);
        run_random_phase(5'd16, 0, 150);
        run_random_phase(5'd1, 75, 130);
        run_random_phase(CFG_W'($urandom_range(0, 31)), 15, 130);
        run_random_phase(5'd0, 0, 130);

        wait_drained();
        repeat (2 * FRAMES + 4) @(posedge i_clk);
        if (error_count == 0 && outcome_queue.size() == 0) begin
            $display("lru_page_replacement verification clean");
        end else begin
            $display("lru_page_replacement verification failed");
        end
        $finish;
    end

endmodule
